/* src/cfc_pkg.sv */
// ----------------------------------------------------------------------------
// cfc_pkg
// Types and constants shared by the chunk frustum cull unit and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

    // Field widths
    localparam int SLOT_W     = 3;
    localparam int COORD_W    = 16;
    localparam int NORM_W     = 16;
    localparam int OFS_W      = 48;
    localparam int WIDTH_W    = 9;
    localparam int HEIGHT_W   = 11;
    localparam int DEPTH_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Arithmetic widths: box bounds, axis products and the plane sum
    localparam int BND_W  = 27;
    localparam int PROD_W = 43;
    localparam int SUM_W  = 50;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd16;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd256;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 9'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_DEPTH  = 2'd2;

    // Request and result codes
    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TEST      = 1'b1;
    localparam logic KIND_LOAD_ACK = 1'b0;
    localparam logic KIND_TEST     = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [SLOT_W-1:0]        plane_slot;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [OFS_W-1:0]  plane_offset;
        logic signed [COORD_W-1:0] chunk_x;
        logic signed [COORD_W-1:0] chunk_z;
    } cfc_req_t;

    typedef struct packed {
        logic result_kind;
        logic visible;
    } cfc_result_t;

    // One plane read out of the store, with its pipeline tags
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [OFS_W-1:0]  plane_offset;
    } cfc_plane_t;

    // Chunk box in voxel units; y runs from zero to height
    typedef struct packed {
        logic signed [BND_W-1:0] x0;
        logic signed [BND_W-1:0] x1;
        logic signed [BND_W-1:0] z0;
        logic signed [BND_W-1:0] z1;
        logic signed [BND_W-1:0] height;
    } cfc_box_t;

    // Per-plane verdict leaving the evaluator
    typedef struct packed {
        logic valid;
        logic last;
        logic cull;
    } cfc_eval_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_SWEEP,
        ST_DRAIN
    } cfc_state_t;

endpackage

`default_nettype wire

/* src/cfc_plane_mem.sv */
// ----------------------------------------------------------------------------
// cfc_plane_mem
// Plane store: normals and offsets, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_plane_mem #(
    parameter int PLANE_COUNT = 6,
    parameter int IDX_W       = 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [IDX_W-1:0]             wr_addr,
    input  wire logic [3*cfc_pkg::NORM_W-1:0] wr_normal,
    input  wire logic [cfc_pkg::OFS_W-1:0]    wr_offset,
    input  wire logic                         rd_en,
    input  wire logic [IDX_W-1:0]             rd_addr,
    input  wire logic                         rd_last,
    output cfc_pkg::cfc_plane_t               rd_plane
);
    import cfc_pkg::*;

    logic [3*NORM_W-1:0] normal_mem [PLANE_COUNT];
    logic [OFS_W-1:0]    offset_mem [PLANE_COUNT];
    logic                entry_valid_reg [PLANE_COUNT];

    logic [3*NORM_W-1:0] rd_normal_reg;
    logic [OFS_W-1:0]    rd_offset_reg;
    logic                rd_hit_reg;
    logic                rd_valid_reg;
    logic                rd_last_reg;

    // Storage and registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            normal_mem[wr_addr] <= wr_normal;
            offset_mem[wr_addr] <= wr_offset;
        end
        if (rd_en)
        begin
            rd_normal_reg <= normal_mem[rd_addr];
            rd_offset_reg <= offset_mem[rd_addr];
        end
    end

    // Entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
            rd_hit_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= rd_en;
            rd_last_reg  <= rd_en & rd_last;
            if (rd_en)
            begin
                rd_hit_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_plane.valid        = rd_valid_reg;
        rd_plane.last         = rd_last_reg;
        rd_plane.normal_x     = rd_hit_reg ? rd_normal_reg[NORM_W-1:0] : '0;
        rd_plane.normal_y     = rd_hit_reg ? rd_normal_reg[2*NORM_W-1:NORM_W] : '0;
        rd_plane.normal_z     = rd_hit_reg ? rd_normal_reg[3*NORM_W-1:2*NORM_W] : '0;
        rd_plane.plane_offset = rd_hit_reg ? rd_offset_reg : '0;
    end

endmodule

`default_nettype wire

/* src/cfc_plane_eval.sv */
// ----------------------------------------------------------------------------
// cfc_plane_eval
// Plane evaluator: positive vertex, three axis products, then sum and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_plane_eval (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfc_pkg::cfc_plane_t plane,
    input  wire cfc_pkg::cfc_box_t   box,
    output cfc_pkg::cfc_eval_t       verdict
);
    import cfc_pkg::*;

    logic signed [BND_W-1:0]  bx;
    logic signed [BND_W-1:0]  by;
    logic signed [BND_W-1:0]  bz;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] pz_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [OFS_W-1:0]  ofs_reg;
    logic                     p_valid_reg;
    logic                     p_last_reg;
    logic signed [SUM_W-1:0]  sum;
    logic                     cull_reg;
    logic                     v_valid_reg;
    logic                     v_last_reg;

    // Positive vertex: box maximum where the normal is non-negative
    always_comb
    begin
        bx = plane.normal_x[NORM_W-1] ? box.x0 : box.x1;
        by = plane.normal_y[NORM_W-1] ? '0 : box.height;
        bz = plane.normal_z[NORM_W-1] ? box.z0 : box.z1;
        px_next = PROD_W'(plane.normal_x) * PROD_W'(bx);
        py_next = PROD_W'(plane.normal_y) * PROD_W'(by);
        pz_next = PROD_W'(plane.normal_z) * PROD_W'(bz);
    end

    always_comb
    begin
        sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg) + SUM_W'(ofs_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        ofs_reg  <= plane.plane_offset;
        cull_reg <= sum[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            v_valid_reg <= 1'b0;
            v_last_reg  <= 1'b0;
        end
        else
        begin
            p_valid_reg <= plane.valid;
            p_last_reg  <= plane.valid & plane.last;
            v_valid_reg <= p_valid_reg;
            v_last_reg  <= p_valid_reg & p_last_reg;
        end
    end

    always_comb
    begin
        verdict.valid = v_valid_reg;
        verdict.last  = v_last_reg;
        verdict.cull  = cull_reg;
    end

endmodule

`default_nettype wire

/* src/chunk_frustum_cull_unit.sv */
// ----------------------------------------------------------------------------
// chunk_frustum_cull_unit
// Culls terrain chunk columns against a frustum held in a small plane store.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                 Transfer when
//  --------  --------------------------------------  ---------------------------
//  request   start, busy, req                        start && !busy
//  result    result_valid, result                    result_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index,        cfg_valid && cfg_ready
//            cfg_data
//
//  A load item writes its plane at the transfer edge if its slot is below
//  PLANE_COUNT; its acknowledge is strobed in the next cycle either way, and
//  busy stays low, so items may follow back to back. A test item holds busy
//  until its final verdict is out: the first plane read issues in the cycle
//  that forms the box, then one plane a cycle through the store's read port
//  and the shared evaluator, then on through the store's read register and
//  the evaluator's product and sign registers. The result is strobed in the
//  first cycle with busy low, when a new transfer can already be accepted.
//  Reset clears the plane store's valid bits at once, so no sweep is needed.
//  The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_frustum_cull_unit #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire cfc_pkg::cfc_req_t                req,
    output logic                                  result_valid,
    output cfc_pkg::cfc_result_t                  result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cfc_pkg::*;

    localparam int IDX_W  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int SCMP_W = SLOT_W + 2;

    // Configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [DEPTH_W-1:0]  depth_reg;

    // Control
    cfc_state_t          state_reg;
    cfc_state_t          state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic                vis_reg;
    logic                accept;
    logic                accept_load;
    logic                accept_test;
    logic                rd_en;
    logic                rd_last;
    logic                slot_ok;

    // Test item and box
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cz_reg;
    logic signed [BND_W-1:0]   cx_ext;
    logic signed [BND_W-1:0]   cz_ext;
    logic signed [BND_W-1:0]   w_ext;
    logic signed [BND_W-1:0]   d_ext;
    cfc_box_t                  box_reg;

    // Result register
    logic                result_valid_reg;
    cfc_result_t         result_reg;

    cfc_plane_t          rd_plane;
    cfc_eval_t           verdict;

    assign accept      = start && !busy;
    assign accept_load = accept && (req.req_type == REQ_LOAD);
    assign accept_test = accept && (req.req_type == REQ_TEST);
    assign slot_ok     = SCMP_W'(req.plane_slot) < SCMP_W'(PLANE_COUNT);
    assign cfg_ready   = 1'b1;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            depth_reg  <= DEPTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHUNK_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_CHUNK_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_CHUNK_DEPTH:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_test)
                begin
                    state_next = ST_BOUNDS;
                end
            end
            ST_BOUNDS, ST_SWEEP:
            begin
                if (idx_reg == IDX_W'(PLANE_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_DRAIN:
            begin
                if (verdict.valid && verdict.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: issue one plane read a cycle in the bounds and sweep states
    always_comb
    begin
        busy    = 1'b1;
        rd_en   = 1'b0;
        rd_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_BOUNDS, ST_SWEEP:
            begin
                rd_en   = 1'b1;
                rd_last = (idx_reg == IDX_W'(PLANE_COUNT - 1));
            end
            ST_DRAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            vis_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept_test)
            begin
                idx_reg <= '0;
                vis_reg <= 1'b1;
            end
            else
            begin
                if (rd_en)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                // Any plane with the box fully behind it hides the chunk
                if (verdict.valid && verdict.cull)
                begin
                    vis_reg <= 1'b0;
                end
            end
        end
    end

    // Hold the chunk index and form the box in the cycle after the transfer
    assign cx_ext = BND_W'(cx_reg);
    assign cz_ext = BND_W'(cz_reg);
    assign w_ext  = BND_W'(width_reg);
    assign d_ext  = BND_W'(depth_reg);

    always_ff @(posedge clk)
    begin
        if (accept_test)
        begin
            cx_reg <= req.chunk_x;
            cz_reg <= req.chunk_z;
        end
        if (state_reg == ST_BOUNDS)
        begin
            box_reg.x0     <= cx_ext * w_ext;
            box_reg.x1     <= (cx_ext + BND_W'(1)) * w_ext;
            box_reg.z0     <= cz_ext * d_ext;
            box_reg.z1     <= (cz_ext + BND_W'(1)) * d_ext;
            box_reg.height <= BND_W'(height_reg);
        end
    end

    // Result strobe: load acknowledge or the final verdict of a test
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= accept_load || (verdict.valid && verdict.last);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_load)
        begin
            result_reg.result_kind <= KIND_LOAD_ACK;
            result_reg.visible     <= 1'b0;
        end
        else if (verdict.valid && verdict.last)
        begin
            result_reg.result_kind <= KIND_TEST;
            result_reg.visible     <= vis_reg && !verdict.cull;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    cfc_plane_mem #(
        .PLANE_COUNT (PLANE_COUNT),
        .IDX_W       (IDX_W)
    ) u_plane_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept_load && slot_ok),
        .wr_addr   (req.plane_slot[IDX_W-1:0]),
        .wr_normal ({req.normal_z, req.normal_y, req.normal_x}),
        .wr_offset (req.plane_offset),
        .rd_en     (rd_en),
        .rd_addr   (idx_reg),
        .rd_last   (rd_last),
        .rd_plane  (rd_plane)
    );

    cfc_plane_eval u_plane_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .plane   (rd_plane),
        .box     (box_reg),
        .verdict (verdict)
    );

endmodule

`default_nettype wire
